>>> hw/rtl/tvbs_pkg.sv
package tvbs_pkg;

    typedef enum logic [1:0] {
        TYPE_BYTE   = 2'd0,
        TYPE_BOOL   = 2'd1,
        TYPE_INT    = 2'd2,
        TYPE_DOUBLE = 2'd3
    } req_type_t;

    localparam int FRAC_W = 52;
    localparam int SHIFT_W = 6;

    // Normalising shift of a subnormal fraction: distance to move the top set bit
    // of the fraction up to the hidden-bit position (bit 52).
    function automatic logic [SHIFT_W-1:0] frac_norm_shift(input logic [FRAC_W-1:0] frac);
        logic [SHIFT_W-1:0] s;
        s = '0;
        for (int i = 0; i < FRAC_W; i++) begin
            if (frac[i]) begin
                s = SHIFT_W'(FRAC_W - i);
            end
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/typed_value_byte_serializer_core.sv
// Channel   Dir  tdata                 tuser            tlast
// s_axis    in   value[63:0]           req_type[1:0]    -
// m_axis    out  out_byte[7:0]         not_finite       last_byte
//
// Three register stages: input, exponent/shift decode, result word.
// The first byte leaves from the result stage after the input and decode stages.
// An item leaves the byte-wide output as 1 (byte, boolean), 4 (integer)
// or 8 (double) bytes; that output register sets the sustained rate.
// Reset clears the valid bits and the byte index; a stalled output backs up the stages in turn.
module typed_value_byte_serializer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [63:0]               s_axis_tdata,   // [63:0] value
    input  tvbs_pkg::req_type_t       s_axis_tuser,   // [1:0] req_type
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
    output logic                      m_axis_tuser,   // [0] not_finite
    output logic                      m_axis_tlast
);
    import tvbs_pkg::*;

    localparam logic [11:0] EXP_BIAS     = 12'd1022;
    localparam logic [11:0] EXP_SUB_BASE = 12'hC03;   // -1021
    localparam logic [53:0] ROUND_HALF   = 54'h400000;

    // input stage
    logic               s0_valid_reg;
    req_type_t          s0_type_reg;
    logic [63:0]        s0_value_reg;

    // decode stage
    logic               s1_valid_reg;
    req_type_t          s1_type_reg;
    logic [31:0]        s1_low_reg;
    logic               s1_neg_reg;
    logic               s1_bad_reg;
    logic               s1_zero_reg;
    logic               s1_sub_reg;
    logic [51:0]        s1_frac_reg;
    logic [10:0]        s1_bexp_reg;
    logic [SHIFT_W-1:0] s1_shift_reg;

    // result stage
    logic               s2_valid_reg;
    logic [63:0]        s2_word_reg;
    logic [2:0]         s2_idx_reg;
    logic               s2_bad_reg;

    logic               in_accept;
    logic               out_xfer;
    logic               out_done;
    logic               s2_load;
    logic               s1_load;

    logic [52:0]        sig;
    logic [53:0]        rnd;
    logic [31:0]        mag;
    logic [31:0]        mant;
    logic [11:0]        exp12;
    logic [63:0]        word_next;
    logic [2:0]         idx_next;
    logic               bad_next;

    assign out_xfer  = s2_valid_reg && m_axis_tready;
    assign out_done  = out_xfer && (s2_idx_reg == 3'd0);
    assign s2_load   = s1_valid_reg && (!s2_valid_reg || out_done);
    assign s1_load   = s0_valid_reg && (!s1_valid_reg || s2_load);
    assign s_axis_tready = !s0_valid_reg || s1_load;
    assign in_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_idx_reg   <= 3'd0;
        end
        else begin
            if (in_accept) begin
                s0_valid_reg <= 1'b1;
            end
            else if (s1_load) begin
                s0_valid_reg <= 1'b0;
            end

            if (s1_load) begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load) begin
                s1_valid_reg <= 1'b0;
            end

            if (s2_load) begin
                s2_valid_reg <= 1'b1;
                s2_idx_reg   <= idx_next;
            end
            else if (out_done) begin
                s2_valid_reg <= 1'b0;
            end
            else if (out_xfer) begin
                s2_idx_reg <= s2_idx_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_accept) begin
            s0_type_reg  <= s_axis_tuser;
            s0_value_reg <= s_axis_tdata;
        end
        if (s1_load) begin
            s1_type_reg  <= s0_type_reg;
            s1_low_reg   <= s0_value_reg[31:0];
            s1_neg_reg   <= s0_value_reg[63];
            s1_bexp_reg  <= s0_value_reg[62:52];
            s1_frac_reg  <= s0_value_reg[51:0];
            s1_bad_reg   <= (s0_value_reg[62:52] == 11'h7FF);
            s1_sub_reg   <= (s0_value_reg[62:52] == 11'h000);
            s1_zero_reg  <= (s0_value_reg[62:0] == 63'd0);
            s1_shift_reg <= frac_norm_shift(s0_value_reg[51:0]);
        end
        if (s2_load) begin
            s2_word_reg <= word_next;
            s2_bad_reg  <= bad_next;
        end
    end

    // mantissa: top 30 bits of the normalised significand, rounded half up on magnitude
    always_comb begin
        if (s1_sub_reg) begin
            sig = {1'b0, s1_frac_reg} << s1_shift_reg;
        end
        else begin
            sig = {1'b1, s1_frac_reg};
        end
        rnd  = {1'b0, sig} + ROUND_HALF;
        mag  = {1'b0, rnd[53:23]};
        mant = s1_neg_reg ? (32'd0 - mag) : mag;
        if (s1_sub_reg) begin
            exp12 = EXP_SUB_BASE - {6'd0, s1_shift_reg};
        end
        else begin
            exp12 = {1'b0, s1_bexp_reg} - EXP_BIAS;
        end
    end

    always_comb begin
        word_next = '0;
        idx_next  = 3'd0;
        bad_next  = 1'b0;
        unique case (s1_type_reg)
            TYPE_BYTE: begin
                word_next = {56'd0, s1_low_reg[7:0]};
            end
            TYPE_BOOL: begin
                word_next = {63'd0, s1_low_reg[0]};
            end
            TYPE_INT: begin
                word_next = {32'd0, s1_low_reg};
                idx_next  = 3'd3;
            end
            TYPE_DOUBLE: begin
                idx_next = 3'd7;
                bad_next = s1_bad_reg;
                if (!s1_bad_reg && !s1_zero_reg) begin
                    word_next = {mant, {20{exp12[11]}}, exp12};
                end
            end
            default: begin
                word_next = '0;
            end
        endcase
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = s2_word_reg[{s2_idx_reg, 3'b000} +: 8];
    assign m_axis_tuser  = s2_bad_reg;
    assign m_axis_tlast  = (s2_idx_reg == 3'd0);

    // a byte taken that is not the last moves on to the next lower byte
    a_byte_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> (m_axis_tvalid && s2_idx_reg == $past(s2_idx_reg) - 3'd1))
        else $error("serializer skipped or dropped a byte");

    // flag holds across all bytes of one run
    a_flag_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |=> (m_axis_tuser == $past(m_axis_tuser)))
        else $error("not_finite changed inside a run");

    // a decoded item that cannot move on is kept
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> s1_valid_reg)
        else $error("decode stage lost an item");

    // an item entering the output stage starts at a legal byte count
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        s2_load |=> (s2_idx_reg == 3'd0 || s2_idx_reg == 3'd3 || s2_idx_reg == 3'd7))
        else $error("illegal run length");

endmodule

>>> verif/serializer_byte_checker.sv
`timescale 1ns / 1ps

module serializer_byte_checker
    import tvbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    input  req_type_t   s_axis_tuser,   // [1:0] req_type
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    input  logic        m_axis_tuser,   // [0] not_finite
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending,
    output int          checked_bytes
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       not_finite;
    } serial_byte_t;

    serial_byte_t expected_bytes[$];
    serial_byte_t want;
    int           failures = 0;
    int           byte_count = 0;

    assign fail_count    = failures;
    assign checked_bytes = byte_count;

    initial pending = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: MISMATCH on output byte %0d: %s", $time, byte_count, what);
        failures++;
    endtask

    // big-endian: most significant of the 'count' low bytes goes first
    function automatic void queue_word(input logic [31:0] word, input int count,
                                       input logic flag, input logic ends_item);
        serial_byte_t b;
        for (int i = 0; i < count; i++) begin
            b.data       = word[8 * (count - 1 - i) +: 8];
            b.last       = ends_item && (i == count - 1);
            b.not_finite = flag;
            expected_bytes.insert(expected_bytes.size(), b);
        end
    endfunction

    // magnitude in [0.5,1) scaled by 2^30, rounded half away from zero, then signed
    function automatic void encode_double(input logic [63:0] bits,
                                          output logic [31:0] mant,
                                          output logic [31:0] expo,
                                          output logic bad);
        logic [10:0] bexp;
        logic [52:0] sig;
        logic [53:0] rounded;
        int          shift;
        bexp = bits[62:52];
        mant = '0;
        expo = '0;
        bad  = 1'b0;
        shift = 0;
        if (bexp == 11'h7FF) begin
            bad = 1'b1;
        end
        else if (bexp != 11'd0 || bits[51:0] != 52'd0) begin
            if (bexp == 11'd0) begin
                sig = {1'b0, bits[51:0]};
                while (!sig[52]) begin
                    sig = sig << 1;
                    shift++;
                end
                expo = 32'(-1021 - shift);
            end
            else begin
                sig  = {1'b1, bits[51:0]};
                expo = 32'(bexp) - 32'd1022;
            end
            rounded = {1'b0, sig} + 54'h40_0000;
            mant = 32'(rounded >> 23);
            if (bits[63]) begin
                mant = -mant;
            end
        end
    endfunction

    function automatic void serialize_value(input req_type_t kind, input logic [63:0] value);
        logic [31:0] mant;
        logic [31:0] expo;
        logic        bad;
        case (kind)
            TYPE_BYTE: queue_word(32'(value[7:0]), 1, 1'b0, 1'b1);
            TYPE_BOOL: queue_word(32'(value[0]), 1, 1'b0, 1'b1);
            TYPE_INT:  queue_word(value[31:0], 4, 1'b0, 1'b1);
            default:
            begin
                encode_double(value, mant, expo, bad);
                queue_word(mant, 4, bad, 1'b0);
                queue_word(expo, 4, bad, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, data %h", m_axis_tdata));
                end
                else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata !== want.data)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_axis_tdata, want.data));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last_byte %b, expected %b",
                                                  m_axis_tlast, want.last));
                    if (m_axis_tuser !== want.not_finite)
                        report_mismatch($sformatf("not_finite %b, expected %b",
                                                  m_axis_tuser, want.not_finite));
                end
                byte_count++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                serialize_value(s_axis_tuser, s_axis_tdata);
            end
            pending <= expected_bytes.size();
        end
    end

endmodule

>>> verif/typed_value_byte_serializer_core_test.sv
`timescale 1ns / 1ps

module typed_value_byte_serializer_core_test;
    import tvbs_pkg::*;

    localparam int RANDOM_ITEMS = 270;
    localparam int STALL_LIMIT  = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;    // [63:0] value
    req_type_t   s_axis_tuser = TYPE_BYTE;   // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] out_byte
    logic        m_axis_tuser;         // [0] not_finite
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          checked_bytes;
    int          idle_cycles = 0;
    bit          idle_on = 1'b1;
    int          sent_by_kind[4] = '{0, 0, 0, 0};
    int          strings_sent = 0;

    always #4 clk = ~clk;

    typed_value_byte_serializer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    serializer_byte_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_bytes (checked_bytes)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            m_axis_tready <= !idle_on || ($urandom_range(99) >= 36);
        end
    end

    // stall watchdog: nothing moving on either channel for too long
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d bytes outstanding",
                     STALL_LIMIT, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic push_item(input req_type_t kind, input logic [63:0] value);
        while (idle_on && $urandom_range(99) < 36) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= value;
        do @(posedge clk); while (!s_axis_tready);
        sent_by_kind[int'(kind)]++;
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] random_double();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(9))
            0:  // subnormal, spread of normalising shifts
            begin
                v[62:52] = 11'd0;
                v[51:0]  = v[51:0] >> $urandom_range(51);
                if (v[51:0] == 52'd0)
                    v[0] = 1'b1;
            end
            1:
            begin
                v[62:52] = 11'h7FF;
                if ($urandom_range(1) == 0)
                    v[51:0] = '0;
            end
            2:  v[62:0] = '0;
            3:  // rounds up to full scale
            begin
                v[51:22] = '1;
                if (v[62:52] == 11'h7FF || v[62:52] == 11'd0)
                    v[62:52] = 11'd1023;
            end
            4:  // exact half on the rounding boundary
            begin
                v[22:0] = 23'h40_0000;
                if (v[62:52] == 11'h7FF)
                    v[62:52] = 11'd1;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic push_string(input int len);
        logic [63:0] v;
        v = rand64();
        v[31:0] = 32'(len);
        push_item(TYPE_INT, v);
        for (int i = 0; i < len; i++)
            push_item(TYPE_BYTE, rand64());
        strings_sent++;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, unused payload bits, string framing, double corners
        push_item(TYPE_BYTE, 64'h0);
        push_item(TYPE_BYTE, 64'hFFFF_FFFF_FFFF_FFFF);
        push_item(TYPE_BOOL, 64'h0);
        push_item(TYPE_BOOL, 64'h1);
        push_item(TYPE_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
        push_item(TYPE_INT, 64'h0);
        push_item(TYPE_INT, 64'hFFFF_FFFF_8000_0000);
        push_item(TYPE_INT, 64'h0000_0000_7FFF_FFFF);
        push_item(TYPE_INT, 64'h5A5A_5A5A_FFFF_FFFF);
        push_item(TYPE_INT, 64'd3);
        push_item(TYPE_BYTE, 64'h61);
        push_item(TYPE_BYTE, 64'h62);
        push_item(TYPE_BYTE, 64'h63);
        strings_sent++;
        push_item(TYPE_DOUBLE, 64'h0000_0000_0000_0000);   // +0
        push_item(TYPE_DOUBLE, 64'h8000_0000_0000_0000);   // -0
        push_item(TYPE_DOUBLE, 64'h7FF0_0000_0000_0000);   // +inf
        push_item(TYPE_DOUBLE, 64'hFFF0_0000_0000_0000);   // -inf
        push_item(TYPE_DOUBLE, 64'h7FF8_0000_0000_0001);   // NaN
        push_item(TYPE_DOUBLE, 64'h0000_0000_0000_0001);   // smallest subnormal
        push_item(TYPE_DOUBLE, 64'h800F_FFFF_FFFF_FFFF);   // largest subnormal, negative
        push_item(TYPE_DOUBLE, 64'h0010_0000_0000_0000);   // smallest normal
        push_item(TYPE_DOUBLE, 64'h3FF0_0000_0000_0000);   // 1.0
        push_item(TYPE_DOUBLE, 64'hBFF0_0000_0040_0000);   // -1.0 plus exact half
        push_item(TYPE_DOUBLE, 64'h3FF0_0000_003F_FFFF);   // just under half
        push_item(TYPE_DOUBLE, 64'h7FEF_FFFF_FFFF_FFFF);   // max finite, full scale
        drain_outputs();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // quiet stretch: both sides run flat out
            idle_on = !(n >= 140 && n < 220);
            if (n == 120)
                drain_outputs();
            case ($urandom_range(9))
                0, 1:    push_item(TYPE_BYTE, rand64());
                2:       push_item(TYPE_BOOL, rand64());
                3, 4:    push_item(TYPE_INT, rand64());
                5:       push_string($urandom_range(8));
                default: push_item(TYPE_DOUBLE, random_double());
            endcase
        end
        idle_on = 1'b1;

        drain_outputs();
        repeat (16) @(posedge clk);

        $display("items sent: %0d byte, %0d boolean, %0d integer, %0d double (%0d strings)",
                 sent_by_kind[0], sent_by_kind[1], sent_by_kind[2], sent_by_kind[3],
                 strings_sent);
        $display("%0d output bytes compared, %0d failures", checked_bytes, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
